@@ sv/tms_pkg.sv @@
// ---------------------------------------------------------------------------
// tms_pkg: shared types and constants of the touchpad merge smoother
// pad mapping, centring and smoothing constants, queue entry layout
// ---------------------------------------------------------------------------
package tms_pkg;

   localparam int unsigned RAW_W   = 10;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned ALPHA_W = 9;
   localparam int unsigned DZ_W    = 10;
   localparam int unsigned PRESS_W = 8;
   localparam int unsigned CSR_W   = 10;

   // configuration defaults
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd51;
   localparam logic [DZ_W-1:0]    DZ_RESET    = 10'd10;

   // pressure while touched
   localparam logic [PRESS_W-1:0] PRESS_ON = 8'd255;

   // pad mapping
   localparam logic [RAW_W-1:0] LEFT_X_TOP   = 10'd479;
   localparam logic [RAW_W-1:0] RIGHT_X_BASE = 10'd480;
   localparam logic [RAW_W-1:0] RIGHT_Y_TOP  = 10'd942;
   localparam logic [RAW_W-1:0] X_SCALE      = 10'd479;
   localparam logic [RAW_W-1:0] Y_SCALE      = 10'd942;

   // centring: (v - mid) * 65535 / span, quotient by reciprocal with 2^26 scale
   localparam logic [11:0] X_MID       = 12'd479;
   localparam logic [11:0] Y_MID       = 12'd471;
   localparam logic [9:0]  X_SPAN      = 10'd959;
   localparam logic [9:0]  Y_SPAN      = 10'd942;
   localparam logic [16:0] X_RECIP     = 17'd69977;
   localparam logic [16:0] Y_RECIP     = 17'd71240;

   typedef enum logic [0:0] {
      CSR_ALPHA    = 1'b0,
      CSR_DEADZONE = 1'b1
   } csr_index_type;

   // one queue entry between front and back
   typedef struct packed {
      logic                    touched;
      logic signed [POS_W-1:0] tx;
      logic signed [POS_W-1:0] ty;
   } target_type;

endpackage

@@ sv/touchpad_merge_smoother.sv @@
// ---------------------------------------------------------------------------
// touchpad_merge_smoother: merged and smoothed touch position of two pads
// top level with configuration registers, front, target queue and smoother
// ---------------------------------------------------------------------------
// takes one report word per cycle while req_tready is high and gives one
// result word for each, in order. in the front a word is mapped into the
// stored pad state, then classified with a reciprocal estimate of the
// centring quotient; the correction and clamp of that estimate run on the
// way into the target queue. the word is written into the queue and then
// taken into the result register in the smoother once that is free or read.
// the smoother's state loop sustains one word per cycle while rsp_tready
// is high. req_tready falls when the queue together with the words still
// in the front would fill QUEUE_DEPTH; with the default of four a steady
// one-per-cycle stream never sees it fall.
// configuration is written through csr_wr_en, csr_index and csr_wr_data
// (index 0 smoothing alpha in 1/256, index 1 touch deadzone) and must only
// change while no word is in flight.
// ---------------------------------------------------------------------------
module touchpad_merge_smoother #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   // request words
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [0] left_valid, [10:1] left_pad_x, [20:11] left_pad_y, [21] right_valid,
   // [31:22] right_pad_x, [41:32] right_pad_y, [47:42] zero
   input  logic [47:0]                req_tdata,
   // result words
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [15:0] touch_x, [31:16] touch_y, [39:32] touch_pressure
   output logic [39:0]                rsp_tdata,
   // configuration writes
   input  logic                       csr_wr_en,
   input  logic [0:0]                 csr_index,
   input  logic [tms_pkg::CSR_W-1:0]  csr_wr_data
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   // configuration registers
   logic [tms_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [tms_pkg::DZ_W-1:0]    deadzone_ff, deadzone_in;

   logic                              req_fire;
   logic [1:0]                        in_flight;
   logic                              front_valid;
   tms_pkg::target_type               front_target;
   tms_pkg::target_type               queue_head;
   logic                              queue_empty;
   logic [CNT_W-1:0]                  queue_count;
   logic [CNT_W:0]                    occupancy;
   logic                              back_pop;
   logic signed [tms_pkg::POS_W-1:0]  touch_x;
   logic signed [tms_pkg::POS_W-1:0]  touch_y;
   logic [tms_pkg::PRESS_W-1:0]       touch_pressure;

   // register writes, alpha keeps its low nine bits
   always_comb begin
      alpha_in    = alpha_ff;
      deadzone_in = deadzone_ff;
      if (csr_wr_en) begin
         case (tms_pkg::csr_index_type'(csr_index))
            tms_pkg::CSR_ALPHA: begin
               alpha_in = csr_wr_data[tms_pkg::ALPHA_W-1:0];
            end
            tms_pkg::CSR_DEADZONE: begin
               deadzone_in = csr_wr_data[tms_pkg::DZ_W-1:0];
            end
            default: begin
               alpha_in = alpha_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= tms_pkg::ALPHA_RESET;
         deadzone_ff <= tms_pkg::DZ_RESET;
      end else begin
         alpha_ff    <= alpha_in;
         deadzone_ff <= deadzone_in;
      end
   end

   // credit check: every word in the front has a queue slot waiting
   assign occupancy  = {1'b0, queue_count} + (CNT_W+1)'(in_flight);
   assign req_tready = occupancy < (CNT_W+1)'(QUEUE_DEPTH);
   assign req_fire   = req_tvalid && req_tready;

   tms_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (req_fire),
      .left_valid  (req_tdata[0]),
      .left_pad_x  (req_tdata[10:1]),
      .left_pad_y  (req_tdata[20:11]),
      .right_valid (req_tdata[21]),
      .right_pad_x (req_tdata[31:22]),
      .right_pad_y (req_tdata[41:32]),
      .deadzone    (deadzone_ff),
      .in_flight   (in_flight),
      .out_valid   (front_valid),
      .out_target  (front_target)
   );

   // targets wait here while the result side stalls
   tms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_target),
      .pop       (back_pop),
      .pop_data  (queue_head),
      .empty     (queue_empty),
      .count     (queue_count)
   );

   tms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .alpha          (alpha_ff),
      .in_valid       (!queue_empty),
      .in_target      (queue_head),
      .in_pop         (back_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .touch_x        (touch_x),
      .touch_y        (touch_y),
      .touch_pressure (touch_pressure)
   );

   // result word packing
   assign rsp_tdata = {touch_pressure, touch_y, touch_x};

endmodule

@@ sv/tms_front.sv @@
// ---------------------------------------------------------------------------
// tms_front: pad mapping, touch classification and centring
// keeps the mapped pad state and turns each word into a centred target
// ---------------------------------------------------------------------------
module tms_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_fire,
   input  logic                       left_valid,
   input  logic [tms_pkg::RAW_W-1:0]  left_pad_x,
   input  logic [tms_pkg::RAW_W-1:0]  left_pad_y,
   input  logic                       right_valid,
   input  logic [tms_pkg::RAW_W-1:0]  right_pad_x,
   input  logic [tms_pkg::RAW_W-1:0]  right_pad_y,
   input  logic [tms_pkg::DZ_W-1:0]   deadzone,
   output logic [1:0]                 in_flight,
   output logic                       out_valid,
   output tms_pkg::target_type        out_target
);

   // mapped pad state
   logic [tms_pkg::RAW_W-1:0] left_raw_x_ff, left_raw_x_in;
   logic [tms_pkg::RAW_W-1:0] left_raw_y_ff, left_raw_y_in;
   logic [tms_pkg::RAW_W-1:0] right_raw_x_ff, right_raw_x_in;
   logic [tms_pkg::RAW_W-1:0] right_raw_y_ff, right_raw_y_in;
   logic                      s1_vld_ff, s1_vld_in;

   // stage two: reciprocal estimates awaiting correction
   logic        s2_vld_ff, s2_vld_in;
   logic        touched_ff, touched_in;
   logic        neg_x_ff, neg_x_in;
   logic        neg_y_ff, neg_y_in;
   logic [25:0] m_x_ff, m_x_in;
   logic [25:0] m_y_ff, m_y_in;
   logic [16:0] q0_x_ff, q0_x_in;
   logic [16:0] q0_y_ff, q0_y_in;

   logic [18:0] ly_scaled;
   logic [18:0] ry_scaled;
   logic [19:0] lx_scaled;
   logic [19:0] rx_scaled;

   logic                      right_hit;
   logic                      left_hit;
   logic [tms_pkg::RAW_W-1:0] pick_x;
   logic [tms_pkg::RAW_W-1:0] pick_y;
   logic signed [11:0]        dx;
   logic signed [11:0]        dy;
   logic [9:0]                mag_x;
   logic [9:0]                mag_y;
   logic [42:0]               prod_x;
   logic [42:0]               prod_y;

   logic [26:0] rem_x;
   logic [26:0] rem_y;
   logic [17:0] q_x;
   logic [17:0] q_y;

   // floor(p / 1023) for p below 2^20 - 1: one compare and increment
   function automatic logic [9:0] div1023(input logic [19:0] p);
      logic [9:0]  q;
      logic [10:0] r;
      q = p[19:10];
      r = {1'b0, p[9:0]} + {1'b0, q};
      if (r >= 11'd1023) begin
         q = q + 10'd1;
      end
      return q;
   endfunction

   // sign and clamp to int16
   function automatic logic signed [15:0] clamp16(input logic neg, input logic [17:0] q);
      logic signed [15:0] v;
      if (neg) begin
         if (q > 18'd32768) begin
            v = 16'sh8000;
         end else begin
            v = 16'(-q);
         end
      end else begin
         if (q > 18'd32767) begin
            v = 16'sh7FFF;
         end else begin
            v = q[15:0];
         end
      end
      return v;
   endfunction

   // --- mapping on acceptance ---
   assign ly_scaled = 19'(left_pad_y) * 19'(tms_pkg::X_SCALE);
   assign ry_scaled = 19'(right_pad_y) * 19'(tms_pkg::X_SCALE);
   assign lx_scaled = 20'(left_pad_x) * 20'(tms_pkg::Y_SCALE);
   assign rx_scaled = 20'(right_pad_x) * 20'(tms_pkg::Y_SCALE);

   always_comb begin
      left_raw_x_in  = left_raw_x_ff;
      left_raw_y_in  = left_raw_y_ff;
      right_raw_x_in = right_raw_x_ff;
      right_raw_y_in = right_raw_y_ff;
      if (in_fire && left_valid) begin
         if (left_pad_x != '0 || left_pad_y != '0) begin
            left_raw_x_in = tms_pkg::LEFT_X_TOP - div1023({1'b0, ly_scaled});
            left_raw_y_in = div1023(lx_scaled);
         end else begin
            left_raw_x_in = '0;
            left_raw_y_in = '0;
         end
      end
      if (in_fire && right_valid) begin
         if (right_pad_x != '0 || right_pad_y != '0) begin
            right_raw_x_in = tms_pkg::RIGHT_X_BASE + div1023({1'b0, ry_scaled});
            right_raw_y_in = tms_pkg::RIGHT_Y_TOP - div1023(rx_scaled);
         end else begin
            right_raw_x_in = '0;
            right_raw_y_in = '0;
         end
      end
   end

   assign s1_vld_in = in_fire;

   // --- classification and reciprocal estimate ---
   always_comb begin
      right_hit = (right_raw_x_ff > deadzone) || (right_raw_y_ff > deadzone);
      left_hit  = (left_raw_x_ff > deadzone) || (left_raw_y_ff > deadzone);
      pick_x    = right_hit ? right_raw_x_ff : left_raw_x_ff;
      pick_y    = right_hit ? right_raw_y_ff : left_raw_y_ff;
      dx        = signed'({2'b00, pick_x}) - signed'(tms_pkg::X_MID);
      dy        = signed'({2'b00, pick_y}) - signed'(tms_pkg::Y_MID);
      mag_x     = dx[11] ? 10'(-dx) : dx[9:0];
      mag_y     = dy[11] ? 10'(-dy) : dy[9:0];
      // times 65535 as shift and subtract
      m_x_in    = {mag_x, 16'b0} - {16'b0, mag_x};
      m_y_in    = {mag_y, 16'b0} - {16'b0, mag_y};
      prod_x    = 43'(m_x_in) * 43'(tms_pkg::X_RECIP);
      prod_y    = 43'(m_y_in) * 43'(tms_pkg::Y_RECIP);
      q0_x_in   = prod_x[42:26];
      q0_y_in   = prod_y[42:26];
      neg_x_in  = dx[11];
      neg_y_in  = dy[11];
      touched_in = right_hit || left_hit;
      s2_vld_in = s1_vld_ff;
   end

   // --- correction: estimate is exact or one short ---
   always_comb begin
      rem_x = 27'(m_x_ff) - 27'(q0_x_ff) * 27'(tms_pkg::X_SPAN);
      rem_y = 27'(m_y_ff) - 27'(q0_y_ff) * 27'(tms_pkg::Y_SPAN);
      q_x   = (rem_x >= 27'(tms_pkg::X_SPAN)) ? 18'(q0_x_ff) + 18'd1 : 18'(q0_x_ff);
      q_y   = (rem_y >= 27'(tms_pkg::Y_SPAN)) ? 18'(q0_y_ff) + 18'd1 : 18'(q0_y_ff);
      out_target.touched = touched_ff;
      out_target.tx      = clamp16(neg_x_ff, q_x);
      out_target.ty      = clamp16(neg_y_ff, q_y);
   end

   assign out_valid = s2_vld_ff;
   assign in_flight = {1'b0, s1_vld_ff} + {1'b0, s2_vld_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         left_raw_x_ff  <= '0;
         left_raw_y_ff  <= '0;
         right_raw_x_ff <= '0;
         right_raw_y_ff <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
      end else begin
         left_raw_x_ff  <= left_raw_x_in;
         left_raw_y_ff  <= left_raw_y_in;
         right_raw_x_ff <= right_raw_x_in;
         right_raw_y_ff <= right_raw_y_in;
         s1_vld_ff      <= s1_vld_in;
         s2_vld_ff      <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      touched_ff <= touched_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      m_x_ff     <= m_x_in;
      m_y_ff     <= m_y_in;
      q0_x_ff    <= q0_x_in;
      q0_y_ff    <= q0_y_in;
   end

endmodule

@@ sv/tms_queue.sv @@
// ---------------------------------------------------------------------------
// tms_queue: short queue of centred targets
// show-ahead fifo between the front and the smoother
// ---------------------------------------------------------------------------
module tms_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  tms_pkg::target_type                 push_data,
   input  logic                                pop,
   output tms_pkg::target_type                 pop_data,
   output logic                                empty,
   output logic [$clog2(DEPTH+1)-1:0]          count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   tms_pkg::target_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   // the top level's credit check must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != CNT_W'(DEPTH))
      else $error("target queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("target queue underflow");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("target queue count lost a push");

endmodule

@@ sv/tms_back.sv @@
// ---------------------------------------------------------------------------
// tms_back: exponential smoother and result register
// snaps on first touch, then follows with a q8 weight, clears on release
// ---------------------------------------------------------------------------
module tms_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tms_pkg::ALPHA_W-1:0]       alpha,
   input  logic                              in_valid,
   input  tms_pkg::target_type               in_target,
   output logic                              in_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tms_pkg::POS_W-1:0]  touch_x,
   output logic signed [tms_pkg::POS_W-1:0]  touch_y,
   output logic [tms_pkg::PRESS_W-1:0]       touch_pressure
);

   logic signed [tms_pkg::POS_W-1:0] smooth_x_ff, smooth_x_in;
   logic signed [tms_pkg::POS_W-1:0] smooth_y_ff, smooth_y_in;
   logic                             was_touching_ff, was_touching_in;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic signed [tms_pkg::POS_W-1:0] out_x_ff, out_x_in;
   logic signed [tms_pkg::POS_W-1:0] out_y_ff, out_y_in;
   logic [tms_pkg::PRESS_W-1:0]      out_press_ff, out_press_in;

   logic [tms_pkg::ALPHA_W-1:0] alpha_sat;
   logic signed [9:0]           wa;
   logic signed [9:0]           wb;
   logic signed [26:0]          mix_x;
   logic signed [26:0]          mix_y;
   logic signed [26:0]          adj_x;
   logic signed [26:0]          adj_y;
   logic signed [26:0]          avg_x;
   logic signed [26:0]          avg_y;

   assign in_pop = in_valid && (!rsp_vld_ff || rsp_ready);

   // weighted mix, divided by 256 with truncation toward zero
   always_comb begin
      alpha_sat = (alpha > tms_pkg::ALPHA_ONE) ? tms_pkg::ALPHA_ONE : alpha;
      wa    = signed'({1'b0, alpha_sat});
      wb    = signed'({1'b0, tms_pkg::ALPHA_ONE - alpha_sat});
      mix_x = 27'(wa) * 27'(in_target.tx) + 27'(wb) * 27'(smooth_x_ff);
      mix_y = 27'(wa) * 27'(in_target.ty) + 27'(wb) * 27'(smooth_y_ff);
      adj_x = mix_x[26] ? mix_x + 27'sd255 : mix_x;
      adj_y = mix_y[26] ? mix_y + 27'sd255 : mix_y;
      avg_x = adj_x >>> 8;
      avg_y = adj_y >>> 8;
   end

   always_comb begin
      smooth_x_in     = smooth_x_ff;
      smooth_y_in     = smooth_y_ff;
      was_touching_in = was_touching_ff;
      out_x_in        = out_x_ff;
      out_y_in        = out_y_ff;
      out_press_in    = out_press_ff;
      if (in_pop) begin
         if (in_target.touched) begin
            if (!was_touching_ff) begin
               smooth_x_in = in_target.tx;
               smooth_y_in = in_target.ty;
            end else begin
               smooth_x_in = avg_x[15:0];
               smooth_y_in = avg_y[15:0];
            end
            was_touching_in = 1'b1;
            out_x_in        = smooth_x_in;
            out_y_in        = smooth_y_in;
            out_press_in    = tms_pkg::PRESS_ON;
         end else begin
            smooth_x_in     = '0;
            smooth_y_in     = '0;
            was_touching_in = 1'b0;
            out_x_in        = '0;
            out_y_in        = '0;
            out_press_in    = '0;
         end
      end
   end

   assign rsp_vld_in = in_pop || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_x_ff     <= '0;
         smooth_y_ff     <= '0;
         was_touching_ff <= 1'b0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         smooth_x_ff     <= smooth_x_in;
         smooth_y_ff     <= smooth_y_in;
         was_touching_ff <= was_touching_in;
         rsp_vld_ff      <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_press_ff <= out_press_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign touch_x        = out_x_ff;
   assign touch_y        = out_y_ff;
   assign touch_pressure = out_press_ff;

   // a release must leave the smoother cleared
   assert property (@(posedge clock) disable iff (reset)
      in_pop && !in_target.touched |=> !was_touching_ff && smooth_x_ff == '0
         && smooth_y_ff == '0)
      else $error("smoother not cleared on release");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && out_press_ff == '0 |-> out_x_ff == '0 && out_y_ff == '0)
      else $error("untouched word with non-zero position");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> out_press_ff == '0 || out_press_ff == tms_pkg::PRESS_ON)
      else $error("pressure neither released nor full");

endmodule
